// File: hw/rtl/acr_pkg.sv
// ============================================================================
// acr_pkg
// Shared types and constants for the ARP cache and responder.
// ============================================================================
package acr_pkg;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int OP_W   = 16;
    localparam int LEN_W  = 16;
    localparam int CIDX_W = 2;

    localparam logic [LEN_W-1:0]  ARP_MIN_LEN    = 16'd28;
    localparam logic [OP_W-1:0]   OPCODE_REQUEST = 16'd1;
    localparam logic [MAC_W-1:0]  MAC_BCAST      = 48'hFFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_OWN_IP  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_OWN_MAC = 2'd1;

    typedef enum logic [1:0] {
        REQ_RX     = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_SEND   = 2'd2,
        REQ_LEARN  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        SEND_NONE  = 2'd0,
        SEND_REPLY = 2'd1,
        SEND_BCAST = 2'd2
    } send_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic             en;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } tbl_wr_t;

    typedef struct packed {
        logic             valid;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } tbl_rd_t;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] found_mac;
        send_kind_t       send_kind;
        logic [MAC_W-1:0] dest_mac;
        logic [MAC_W-1:0] target_mac;
        logic [IP_W-1:0]  target_ip_out;
    } result_t;

endpackage

// File: hw/rtl/arp_cache_responder.sv
// ============================================================================
// arp_cache_responder
// Fully associative ARP cache with request responder and lookup port.
// ============================================================================
// Lookup, learn and long received packets are scanned against the table one entry per
// cycle; the worst case is no match, when every entry is read. Send requests and short
// packets skip the scan. The sequencer takes no new item until it has handed the last
// one to the output register, which can hold it while the next item is taken.
// Synchronous reset (aresetn low) clears all valid marks, own_ip and own_mac.
module arp_cache_responder #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [acr_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [acr_pkg::MAC_W-1:0]         cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic [acr_pkg::IP_W-1:0]          s_ip_addr,
    input  logic [acr_pkg::MAC_W-1:0]         s_mac_addr,
    input  logic [acr_pkg::OP_W-1:0]          s_opcode,
    input  logic [acr_pkg::IP_W-1:0]          s_target_ip,
    input  logic [acr_pkg::LEN_W-1:0]         s_pkt_length,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic [acr_pkg::MAC_W-1:0]         m_found_mac,
    output logic [1:0]                        m_send_kind,
    output logic [acr_pkg::MAC_W-1:0]         m_dest_mac,
    output logic [acr_pkg::MAC_W-1:0]         m_target_mac,
    output logic [acr_pkg::IP_W-1:0]          m_target_ip_out
);
    import acr_pkg::*;

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    logic [IP_W-1:0]  own_ip_reg;
    logic [MAC_W-1:0] own_mac_reg;
    logic             m_valid_reg;
    result_t          out_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    tbl_rd_t          rd_data;
    tbl_wr_t          wr;
    logic [IDX_W-1:0] wr_addr;
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    assign cfg_ready = 1'b1;

    // own_mac is stored but drives no output; no result field uses it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_OWN_IP:  own_ip_reg  <= cfg_data[IP_W-1:0];
                REG_OWN_MAC: own_mac_reg <= cfg_data;
                default: begin
                    own_ip_reg  <= own_ip_reg;
                    own_mac_reg <= own_mac_reg;
                end
            endcase
        end
    end

    acr_table #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr),
        .wr_addr (wr_addr)
    );

    acr_ctrl #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_ip_addr    (s_ip_addr),
        .s_mac_addr   (s_mac_addr),
        .s_opcode     (s_opcode),
        .s_target_ip  (s_target_ip),
        .s_pkt_length (s_pkt_length),
        .own_ip       (own_ip_reg),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr           (wr),
        .wr_addr      (wr_addr),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // output register: a finished item waits here while the next is taken
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = out_reg.hit;
    assign m_found_mac     = out_reg.found_mac;
    assign m_send_kind     = out_reg.send_kind;
    assign m_dest_mac      = out_reg.dest_mac;
    assign m_target_mac    = out_reg.target_mac;
    assign m_target_ip_out = out_reg.target_ip_out;

    logic unused_own_mac;
    assign unused_own_mac = ^own_mac_reg;

endmodule

// File: hw/rtl/acr_table.sv
// ============================================================================
// acr_table
// Cache storage: valid bits in flops, IP and MAC in a memory with separate read and
// write addresses and registered read data.
// ============================================================================
module acr_table #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            rd_en,
    input  logic [((CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1)-1:0] rd_addr,
    output acr_pkg::tbl_rd_t                                rd_data,
    input  acr_pkg::tbl_wr_t                                wr,
    input  logic [((CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1)-1:0] wr_addr
);
    import acr_pkg::*;

    logic [IP_W-1:0]  mem_ip  [CACHE_ENTRIES];
    logic [MAC_W-1:0] mem_mac [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] valid_reg;
    tbl_rd_t rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_ip[wr_addr]  <= wr.ip;
            mem_mac[wr_addr] <= wr.mac;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg.valid <= valid_reg[rd_addr];
            rd_reg.ip    <= mem_ip[rd_addr];
            rd_reg.mac   <= mem_mac[rd_addr];
        end
    end

    assign rd_data = rd_reg;

endmodule

// File: hw/rtl/acr_ctrl.sv
// ============================================================================
// acr_ctrl
// Sequencer and shared IP comparator: scans the table one entry per cycle
// for lookups, learns and long received packets, then builds the result item.
// ============================================================================
module acr_ctrl #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            s_valid,
    output logic                                            s_ready,
    input  logic [1:0]                                      s_req_type,
    input  logic [acr_pkg::IP_W-1:0]                        s_ip_addr,
    input  logic [acr_pkg::MAC_W-1:0]                       s_mac_addr,
    input  logic [acr_pkg::OP_W-1:0]                        s_opcode,
    input  logic [acr_pkg::IP_W-1:0]                        s_target_ip,
    input  logic [acr_pkg::LEN_W-1:0]                       s_pkt_length,
    input  logic [acr_pkg::IP_W-1:0]                        own_ip,
    output logic                                            rd_en,
    output logic [((CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1)-1:0] rd_addr,
    input  acr_pkg::tbl_rd_t                                rd_data,
    output acr_pkg::tbl_wr_t                                wr,
    output logic [((CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1)-1:0] wr_addr,
    output logic                                            res_valid,
    input  logic                                            res_ready,
    output acr_pkg::result_t                                res
);
    import acr_pkg::*;

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(CACHE_ENTRIES);

    ctrl_state_t state_reg, state_next;
    req_type_t   kind_reg, kind_next;
    logic [IP_W-1:0]  ip_reg, ip_next;
    logic [MAC_W-1:0] mac_reg, mac_next;
    logic             reply_reg, reply_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             chk_pend_reg, chk_pend_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             hit_reg, hit_next;
    logic [MAC_W-1:0] found_reg, found_next;

    req_type_t in_kind;
    logic      in_long;
    logic      match_now;
    logic      free_now;

    assign in_kind   = req_type_t'(s_req_type);
    assign in_long   = (s_pkt_length >= ARP_MIN_LEN);
    // the one comparator, fed from the table's registered read port
    assign match_now = chk_pend_reg && rd_data.valid && (rd_data.ip == ip_reg);
    assign free_now  = chk_pend_reg && !rd_data.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chk_pend_reg <= 1'b0;
            kind_reg     <= REQ_RX;
        end else begin
            state_reg    <= state_next;
            chk_pend_reg <= chk_pend_next;
            kind_reg     <= kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        ip_reg       <= ip_next;
        mac_reg      <= mac_next;
        reply_reg    <= reply_next;
        scan_cnt_reg <= scan_cnt_next;
        chk_idx_reg  <= chk_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        hit_reg      <= hit_next;
        found_reg    <= found_next;
    end

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        ip_next       = ip_reg;
        mac_next      = mac_reg;
        reply_next    = reply_reg;
        scan_cnt_next = scan_cnt_reg;
        chk_pend_next = 1'b0;
        chk_idx_next  = chk_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        s_ready       = 1'b0;
        res_valid     = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = scan_cnt_reg[IDX_W-1:0];
        wr.en         = 1'b0;
        wr.ip         = ip_reg;
        wr.mac        = mac_reg;
        wr_addr       = chk_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next     = in_kind;
                    ip_next       = s_ip_addr;
                    mac_next      = s_mac_addr;
                    reply_next    = (in_kind == REQ_RX) && in_long &&
                                    (s_opcode == OPCODE_REQUEST) && (s_target_ip == own_ip);
                    scan_cnt_next = '0;
                    free_next     = 1'b0;
                    hit_next      = 1'b0;
                    found_next    = '0;
                    // short packets and send requests never touch the table
                    if ((in_kind == REQ_LOOKUP) || (in_kind == REQ_LEARN) ||
                        ((in_kind == REQ_RX) && in_long)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                rd_en         = (scan_cnt_reg != N_CNT) && !match_now;
                chk_pend_next = rd_en;
                chk_idx_next  = scan_cnt_reg[IDX_W-1:0];
                if (rd_en) begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (free_now && !free_reg) begin
                    free_next     = 1'b1;
                    free_idx_next = chk_idx_reg;
                end
                if (match_now) begin
                    if (kind_reg == REQ_LOOKUP) begin
                        hit_next   = 1'b1;
                        found_next = rd_data.mac;
                    end else begin
                        wr.en   = 1'b1;
                        wr_addr = chk_idx_reg;
                    end
                    state_next = ST_DONE;
                end else if ((scan_cnt_reg == N_CNT) && !chk_pend_reg) begin
                    // no match anywhere: first free slot, else slot 0
                    if (kind_reg != REQ_LOOKUP) begin
                        wr.en   = 1'b1;
                        wr_addr = free_reg ? free_idx_reg : '0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res = '0;
        unique case (kind_reg)
            REQ_RX: begin
                if (reply_reg) begin
                    res.send_kind     = SEND_REPLY;
                    res.dest_mac      = mac_reg;
                    res.target_mac    = mac_reg;
                    res.target_ip_out = ip_reg;
                end
            end
            REQ_LOOKUP: begin
                res.hit       = hit_reg;
                res.found_mac = found_reg;
            end
            REQ_SEND: begin
                res.send_kind     = SEND_BCAST;
                res.dest_mac      = MAC_BCAST;
                res.target_ip_out = ip_reg;
            end
            REQ_LEARN: begin
                res = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/acr_checker.sv
// ============================================================================
// acr_checker
// Port-level checks for the ARP cache and responder, bound to the top level.
// ============================================================================
module acr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_hit,
    input logic [acr_pkg::MAC_W-1:0]   m_found_mac,
    input logic [1:0]                  m_send_kind,
    input logic [acr_pkg::MAC_W-1:0]   m_dest_mac,
    input logic [acr_pkg::MAC_W-1:0]   m_target_mac,
    input logic [acr_pkg::IP_W-1:0]    m_target_ip_out
);
    import acr_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_found_mac) &&
        $stable(m_send_kind) && $stable(m_dest_mac) && $stable(m_target_mac) &&
        $stable(m_target_ip_out))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready high right after an accepted item");

    a_hit_sends_nothing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_send_kind == SEND_NONE)
        else $error("lookup hit with a packet to send");

    a_bcast_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_send_kind == SEND_BCAST) |->
        (m_dest_mac == MAC_BCAST) && (m_target_mac == '0))
        else $error("broadcast request with bad MAC fields");

    a_miss_zero_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_found_mac == '0)
        else $error("found MAC set without a hit");

endmodule

bind arp_cache_responder acr_checker u_acr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_hit           (m_hit),
    .m_found_mac     (m_found_mac),
    .m_send_kind     (m_send_kind),
    .m_dest_mac      (m_dest_mac),
    .m_target_mac    (m_target_mac),
    .m_target_ip_out (m_target_ip_out)
);
